@@ rtl/core/geometric_history_branch_predictor_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the geometric history branch predictor
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GEOMETRIC_HISTORY_BRANCH_PREDICTOR_ASSERT_SVH
`define GEOMETRIC_HISTORY_BRANCH_PREDICTOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GHBP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("assertion failed: same-cycle check");

// Consequent must hold in the cycle after the antecedent.
`define GHBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("assertion failed: next-cycle check");

`endif

@@ rtl/core/ghbp_pkg.sv @@
// ----------------------------------------------------------------------------
// ghbp_pkg
// Constants, types and helper functions of the geometric history predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package ghbp_pkg;

    localparam int NUM_TABLES    = 8;
    localparam int INDEX_BITS    = 10;
    localparam int COUNTER_LIMIT = 32;

    localparam int PC_W     = 32;
    localparam int VOTE_W   = 9;
    localparam int TBL_SIZE = 1 << INDEX_BITS;
    localparam int CNT_W    = $clog2(COUNTER_LIMIT) + 1;
    localparam int SUM_W    = CNT_W + $clog2(NUM_TABLES) + 1;

    localparam int unsigned HIST_LEN [8] = '{0, 4, 8, 32, 64, 34, 55, 89};

    typedef logic        [INDEX_BITS-1:0] t_idx;
    typedef logic signed [CNT_W-1:0]      t_cnt;
    typedef logic signed [SUM_W-1:0]      t_sum;
    typedef logic signed [VOTE_W-1:0]     t_vote;

    localparam t_cnt CNT_MAX = t_cnt'(COUNTER_LIMIT - 1);
    localparam t_cnt CNT_MIN = t_cnt'(-COUNTER_LIMIT);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic clear;   // zero one row of every table
        logic load;    // capture the input beat and form the indices
        logic read;    // read the indexed counters
        logic sum;     // add up the vote
        logic commit;  // write back, shift history, load the output register
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
    } t_dp_stat;

    // History bits that reach table t's index.
    function automatic t_idx hist_mask(input int t);
        t_idx m;
        m = '0;
        for (int i = 0; i < INDEX_BITS; i++) begin
            m[i] = (i < HIST_LEN[t[2:0]]);
        end
        return m;
    endfunction

    // Saturating step toward the outcome.
    function automatic t_cnt cnt_step(input t_cnt c, input logic up);
        t_cnt r;
        r = c;
        if (up) begin
            if (c < CNT_MAX) r = c + t_cnt'(1);
        end else begin
            if (c > CNT_MIN) r = c - t_cnt'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/ghbp_if.sv @@
// ----------------------------------------------------------------------------
// ghbp_req_if / ghbp_rsp_if
// Valid/ready channels for prediction requests and their results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ghbp_req_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [ghbp_pkg::PC_W-1:0]   pc;
    logic                        outcome;

    modport source (output valid, kind, pc, outcome, input ready);
    modport sink   (input valid, kind, pc, outcome, output ready);
endinterface

interface ghbp_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        taken;
    logic signed [ghbp_pkg::VOTE_W-1:0] vote_sum;
    logic                        mispredicted;

    modport source (output valid, taken, vote_sum, mispredicted, input ready);
    modport sink   (input valid, taken, vote_sum, mispredicted, output ready);
endinterface

`default_nettype wire

@@ rtl/core/ghbp_ctrl.sv @@
// ----------------------------------------------------------------------------
// ghbp_ctrl
// Sequencer: clearing pass after reset, then read, sum and commit per item.
// ----------------------------------------------------------------------------
`default_nettype none

module ghbp_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output ghbp_pkg::t_dp_cmd       o_cmd,
    input  wire ghbp_pkg::t_dp_stat i_stat
);
    import ghbp_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_WRITE;
            end
            ST_WRITE: begin
                // hold until the output register can take the beat
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        if (o_cmd.commit)     n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
        else                  n_out_valid = r_out_valid;
    end

endmodule

`default_nettype wire

@@ rtl/core/ghbp_datapath.sv @@
// ----------------------------------------------------------------------------
// ghbp_datapath
// Counter tables, global history, vote adder and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ghbp_datapath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire ghbp_pkg::t_dp_cmd            i_cmd,
    output ghbp_pkg::t_dp_stat                o_stat,
    input  wire logic                         i_kind,
    input  wire logic [ghbp_pkg::PC_W-1:0]    i_pc,
    input  wire logic                         i_outcome,
    output logic                              o_taken,
    output ghbp_pkg::t_vote                   o_vote_sum,
    output logic                              o_mispredicted
);
    import ghbp_pkg::*;

    t_idx  r_clr_addr;
    t_idx  r_hist;
    logic  r_kind;
    logic  r_outcome;
    t_idx  r_idx [NUM_TABLES];
    t_cnt  r_rd  [NUM_TABLES];
    t_sum  r_vote;
    logic  r_taken;
    logic  r_miss;
    logic  r_o_taken;
    t_vote r_o_vote;
    logic  r_o_miss;

    t_sum  n_vote;
    logic  n_taken;
    logic  w_update;

    assign o_stat.clear_last = (r_clr_addr == '1);
    assign w_update          = i_cmd.commit && r_kind && r_miss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_hist     <= '0;
        end else begin
            if (i_cmd.clear) r_clr_addr <= r_clr_addr + t_idx'(1);
            if (i_cmd.commit && r_kind) r_hist <= {r_hist[INDEX_BITS-2:0], r_outcome};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= i_kind;
            r_outcome <= i_outcome;
            for (int t = 0; t < NUM_TABLES; t++) begin
                r_idx[t] <= i_pc[INDEX_BITS-1:0] ^ (r_hist & hist_mask(t));
            end
        end
    end

    for (genvar t = 0; t < NUM_TABLES; t++) begin : g_tbl
        t_cnt r_mem [TBL_SIZE];
        t_idx w_waddr;
        t_cnt w_wdata;

        assign w_waddr = i_cmd.clear ? r_clr_addr : r_idx[t];
        assign w_wdata = i_cmd.clear ? '0 : cnt_step(r_rd[t], r_outcome);

        always_ff @(posedge i_clk) begin
            if (i_cmd.clear || w_update) r_mem[w_waddr] <= w_wdata;
            if (i_cmd.read) r_rd[t] <= r_mem[r_idx[t]];
        end
    end

    always_comb begin
        n_vote = t_sum'(NUM_TABLES / 2);
        for (int t = 0; t < NUM_TABLES; t++) begin
            n_vote = n_vote + t_sum'(r_rd[t]);
        end
        n_taken = (n_vote > t_sum'(0));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            r_vote  <= n_vote;
            r_taken <= n_taken;
            r_miss  <= r_kind && (n_taken != r_outcome);
        end
        if (i_cmd.commit) begin
            r_o_taken <= r_taken;
            r_o_vote  <= VOTE_W'(r_vote);
            r_o_miss  <= r_miss;
        end
    end

    assign o_taken        = r_o_taken;
    assign o_vote_sum     = r_o_vote;
    assign o_mispredicted = r_o_miss;

endmodule

`default_nettype wire

@@ rtl/core/geometric_history_branch_predictor.sv @@
// ----------------------------------------------------------------------------
// geometric_history_branch_predictor
// Summed-counter direction predictor with per-table global history lengths.
//
//   channel  dir  beat
//   i_req    in   kind, pc, outcome (predict or train)
//   o_rsp    out  taken, vote_sum, mispredicted
//
// An item passes through four steps: accept, counter read, vote sum, write-back/commit.
// The read-modify-write of the counter tables sets these steps.
// After reset a clearing pass zeroes one row of all tables per cycle,
// over all 2^INDEX_BITS (1024) rows, with i_req.ready low.
// A stalled result holds the commit step; the next item may be accepted
// while the previous result waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "geometric_history_branch_predictor_assert.svh"

module geometric_history_branch_predictor (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ghbp_req_if.sink   i_req,
    ghbp_rsp_if.source o_rsp
);
    import ghbp_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    ghbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    ghbp_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_kind         (i_req.kind),
        .i_pc           (i_req.pc),
        .i_outcome      (i_req.outcome),
        .o_taken        (o_rsp.taken),
        .o_vote_sum     (o_rsp.vote_sum),
        .o_mispredicted (o_rsp.mispredicted)
    );

    // one item in flight: an accepted beat closes the input side
    `GHBP_ASSERT_NEXT(a_one_in_flight, i_req.valid && i_req.ready, !i_req.ready)
    // no item is taken while the tables are being cleared
    `GHBP_ASSERT_NOW(a_no_accept_in_clear, w_cmd.clear, !i_req.ready)
    // a new result only appears after a commit
    `GHBP_ASSERT_NOW(a_valid_from_commit, $rose(o_rsp.valid), $past(w_cmd.commit))

endmodule

`default_nettype wire
